/* hdl/sit_pkg.sv */
// ----------------------------------------------------------------------------
// sit_pkg: shared types and constants for the sorted insert table
// Payload structs, status codes and the link that runs between cells.
// ----------------------------------------------------------------------------
package sit_pkg;

  localparam int CAPACITY    = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BAD_IDX  = 2'd2;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  typedef struct packed {
    logic             kind;
    value_t           value;
    logic [IDX_W-1:0] index;
  } in_t;

  typedef struct packed {
    logic [CNT_W-1:0] position;
    value_t           stored;
    logic [CNT_W-1:0] count;
    logic [1:0]       status;
  } out_t;

  // What a cell hands to the cell above it.
  typedef struct packed {
    value_t entry;
    logic   valid;
    logic   gt;
  } link_t;

endpackage

/* hdl/sit_cell.sv */
// ----------------------------------------------------------------------------
// sit_cell: one slot of the sorted insert table
// Holds one entry, compares it with the incoming value and shifts up on insert.
// ----------------------------------------------------------------------------
module sit_cell #(
  parameter int IDX = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         ins,
  input  sit_pkg::value_t              value,
  input  logic                         rd_sel,
  input  sit_pkg::link_t               prev,
  output sit_pkg::link_t               link,
  output logic [sit_pkg::CNT_W-1:0]    pos_part,
  output sit_pkg::value_t              rd_part
);
  import sit_pkg::*;

  value_t entry_r, entry_nxt;
  logic   valid_r, valid_nxt;
  logic   gt;
  logic   take_v;

  assign gt     = valid_r && (entry_r > value);
  // The lowest cell that is larger, or the first empty one, takes the value.
  assign take_v = ins && !prev.gt && (gt || (!valid_r && prev.valid));

  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    if (ins && prev.gt) begin
      entry_nxt = prev.entry;
      valid_nxt = 1'b1;
    end else if (take_v) begin
      entry_nxt = value;
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign link     = '{entry: entry_r, valid: valid_r, gt: gt};
  assign pos_part = take_v ? CNT_W'(IDX) : '0;
  assign rd_part  = (rd_sel && valid_r) ? entry_r : '0;

endmodule

/* hdl/sorted_insert_table.sv */
// ----------------------------------------------------------------------------
// sorted_insert_table: ascending table of signed values, built as a cell chain
// Inserts keep order (equal values stay in arrival order); reads fetch by index.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_item and raise start; the beat is taken at the edge where start
//   is high and busy is low. busy stays low: every cell compares its entry
//   with the new value and shifts in the same cycle, so one item is taken
//   per clock.
//   The result appears on out_item in the cycle after the input beat, with
//   out_valid high for exactly that cycle. The receiver cannot stall; a
//   result that is not taken in its cycle is gone.
//   Insert: position is where the value landed, count the new fill. A full
//   table rejects it with status full and stays unchanged.
//   Read: stored is the entry at index; an index at or past the fill
//   returns status bad index and stored zero.
//   Reset (rst_n low, synchronous) empties the table; entry contents are
//   not cleared, only the per-cell valid bits and the fill count.
// ----------------------------------------------------------------------------
module sorted_insert_table (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  sit_pkg::in_t  in_item,
  output logic          out_valid,
  output sit_pkg::out_t out_item
);
  import sit_pkg::*;

  logic             accept;
  logic             full;
  logic             ins;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             out_valid_r;
  out_t             out_r, out_nxt;

  link_t            links [CAPACITY+1];
  logic [CNT_W-1:0] pos_parts [CAPACITY];
  value_t           rd_parts [CAPACITY];
  logic [CNT_W-1:0] pos_any;
  value_t           rd_any;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (fill_r == CNT_W'(CAPACITY));
  assign ins    = accept && (in_item.kind == KIND_INSERT) && !full;

  // Bottom of the chain: nothing below is larger, and it counts as filled.
  assign links[0] = '{entry: '0, valid: 1'b1, gt: 1'b0};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sit_cell #(.IDX(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ins      (ins),
      .value    (in_item.value),
      .rd_sel   (in_item.index == IDX_W'(i)),
      .prev     (links[i]),
      .link     (links[i+1]),
      .pos_part (pos_parts[i]),
      .rd_part  (rd_parts[i])
    );
  end

  always_comb begin
    pos_any = '0;
    rd_any  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      pos_any = pos_any | pos_parts[i];
      rd_any  = rd_any | rd_parts[i];
    end
  end

  always_comb begin
    fill_nxt = ins ? fill_r + CNT_W'(1) : fill_r;
    out_nxt  = '{position: '0, stored: '0, count: fill_nxt, status: ST_OK};
    if (in_item.kind == KIND_INSERT) begin
      if (full) begin
        out_nxt.status = ST_FULL;
      end else begin
        out_nxt.position = pos_any;
      end
    end else begin
      if (CNT_W'(in_item.index) >= fill_r) begin
        out_nxt.status = ST_BAD_IDX;
      end else begin
        out_nxt.stored = rd_any;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      out_valid_r <= accept;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
